/* hdl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared widths, codes and saturating helpers for the contiguous frame
// allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int NUM_FRAMES = 4096;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int CNT_W      = FRAME_W + 1;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_RUN  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_IN_USE = CFG_IDX_W'(0),
    REG_USABLE_COUNT  = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RSV_RD,
    S_RSV_CHK,
    S_MOD,
    S_SCAN,
    S_MARK,
    S_FREE
  } state_t;

  function automatic logic [CNT_W-1:0] sat_limit(input logic [CNT_W-1:0] v);
    return (v > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : v;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > (CNT_W+1)'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : sum[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

endpackage

/* hdl/cfa_ram.sv */
// ----------------------------------------------------------------------------
// cfa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/cfa_rem.sv */
// ----------------------------------------------------------------------------
// cfa_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle, used to
// fold a stale search start into the current frame total.
// ----------------------------------------------------------------------------
module cfa_rem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cfa_pkg::CNT_W-1:0]  dividend,
  input  logic [cfa_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [cfa_pkg::FRAME_W-1:0] remainder
);
  import cfa_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  partial;
  logic [CNT_W-1:0]  shreg;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial     = {partial, shreg[CNT_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign remainder = partial[FRAME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active  <= 1'b1;
        step    <= STEP_W'(CNT_W - 1);
        partial <= '0;
        shreg   <= dividend;
      end else if (active) begin
        partial <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
        shreg   <= {shreg[CNT_W-2:0], 1'b0};
        step    <= step - 1'b1;
        if (step == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/contiguous_frame_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// Next-fit contiguous page frame allocator over used and reserved frame maps
// held in RAM, scanned one frame per cycle.
//
//   channel   signals                                   direction
//   command   start, busy, command, frame_index,        in  (start & !busy)
//             page_count
//   result    done, status, base_frame,                 out (one cycle strobe)
//             free_count_out, used_count_out,
//             allocated_pages_out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in  (valid & ready)
//
// reset and clear sweep both maps, one frame a cycle, busy throughout
// reserve reads the reserved map, then sets the frame's bit if it was clear;
// free clears used-map bits from frame_index for page_count frames or until
// the frame total; allocate folds the search start in the remainder unit,
// scans up to the frame total of frames via the map read port, marks the run
// results cannot be held off; config is accepted every cycle
// ----------------------------------------------------------------------------
module contiguous_frame_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     command,
  input  logic [cfa_pkg::FRAME_W-1:0]    frame_index,
  input  logic [cfa_pkg::CNT_W-1:0]      page_count,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [cfa_pkg::FRAME_W-1:0]    base_frame,
  output logic [cfa_pkg::CNT_W-1:0]      free_count_out,
  output logic [cfa_pkg::CNT_W-1:0]      used_count_out,
  output logic [cfa_pkg::CNT_W-1:0]      allocated_pages_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfa_pkg::CNT_W-1:0]      cfg_data
);
  import cfa_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   usable_frame_count;
  logic [CNT_W-1:0]   total;

  logic [CNT_W-1:0]   search_start;
  logic [CNT_W-1:0]   used_counter;
  logic [CNT_W-1:0]   free_counter;
  logic [CNT_W-1:0]   allocated_counter;

  logic [FRAME_W-1:0] req_index;
  logic [CNT_W-1:0]   req_count;
  logic               reply;
  logic [FRAME_W-1:0] sweep_addr;

  logic [FRAME_W-1:0] scan_addr;
  logic [CNT_W-1:0]   issued;
  logic [FRAME_W-1:0] eval_frame;
  logic               eval_valid;
  logic [CNT_W-1:0]   evaluated;
  logic [CNT_W-1:0]   run;
  logic [FRAME_W-1:0] run_begin;
  logic [CNT_W-1:0]   walk_addr;
  logic [CNT_W-1:0]   walk_left;

  // ram ports
  logic [FRAME_W-1:0] raddr;
  logic               used_we, used_wdata, used_rdata;
  logic [FRAME_W-1:0] used_waddr;
  logic               rsv_we, rsv_wdata, rsv_rdata;
  logic [FRAME_W-1:0] rsv_waddr;

  // remainder unit
  logic               rem_start, rem_done;
  logic [FRAME_W-1:0] rem_value;

  // decode and scan evaluation
  logic               accept;
  cmd_t               cmd_in;
  logic               ignore_in;
  logic               nofit_in;
  logic [CNT_W-1:0]   run_base;
  logic [CNT_W-1:0]   run_inc;
  logic [FRAME_W-1:0] begin_new;
  logic               frame_free;
  logic               scan_found;
  logic               scan_fail;
  logic               mark_last;
  logic               free_end;
  logic               sweep_end;
  logic [FRAME_W-1:0] scan_wrap;

  logic               fin;
  status_t            fin_status;
  logic [FRAME_W-1:0] fin_base;

  assign busy                = (state != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign free_count_out      = free_counter;
  assign used_count_out      = used_counter;
  assign allocated_pages_out = allocated_counter;
  assign total               = sat_limit(frames_in_use);

  cfa_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_used_map (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (raddr),
    .rdata (used_rdata)
  );

  cfa_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_rsv_map (
    .clk   (clk),
    .we    (rsv_we),
    .waddr (rsv_waddr),
    .wdata (rsv_wdata),
    .raddr (raddr),
    .rdata (rsv_rdata)
  );

  cfa_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (search_start),
    .divisor   (total),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_comb begin
    accept    = start && (state == S_IDLE);
    cmd_in    = cmd_t'(command);
    ignore_in = 1'b0;
    nofit_in  = 1'b0;
    case (cmd_in)
      CMD_RESERVE: ignore_in = ({1'b0, frame_index} >= total);
      CMD_ALLOC: begin
        ignore_in = (page_count == '0);
        nofit_in  = (page_count != '0) && (total == '0);
      end
      CMD_FREE:    ignore_in = (page_count == '0) || (frame_index == '0);
      default:     ignore_in = 1'b0;
    endcase

    // a run never carries over from the last frame to frame 0
    run_base   = (eval_frame == '0) ? '0 : run;
    run_inc    = run_base + 1'b1;
    begin_new  = (run_base == '0) ? eval_frame : run_begin;
    frame_free = !used_rdata && !rsv_rdata;
    scan_found = (state == S_SCAN) && eval_valid && frame_free && (run_inc >= req_count);
    scan_fail  = (state == S_SCAN) && eval_valid && !scan_found &&
                 (CNT_W'(evaluated + 1'b1) == total);
    scan_wrap  = (CNT_W'({1'b0, scan_addr} + 1'b1) == total) ? '0 : scan_addr + 1'b1;
    mark_last  = (state == S_MARK) && (walk_left == CNT_W'(1));
    free_end   = (state == S_FREE) && ((walk_left == '0) || (walk_addr >= total));
    sweep_end  = (state == S_SWEEP) && (sweep_addr == FRAME_W'(NUM_FRAMES - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP:   if (sweep_end) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_CLEAR:   state_next = S_SWEEP;
            CMD_RESERVE: if (!ignore_in) state_next = S_RSV_RD;
            CMD_ALLOC:   if (!ignore_in && !nofit_in) state_next = S_MOD;
            CMD_FREE:    if (!ignore_in) state_next = S_FREE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RSV_RD:  state_next = S_RSV_CHK;
      S_RSV_CHK: state_next = S_IDLE;
      S_MOD:     if (rem_done) state_next = S_SCAN;
      S_SCAN: begin
        if (scan_found) begin
          state_next = S_MARK;
        end else if (scan_fail) begin
          state_next = S_IDLE;
        end
      end
      S_MARK:    if (mark_last) state_next = S_IDLE;
      S_FREE:    if (free_end) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr      = scan_addr;
    used_we    = 1'b0;
    used_waddr = walk_addr[FRAME_W-1:0];
    used_wdata = 1'b0;
    rsv_we     = 1'b0;
    rsv_waddr  = req_index;
    rsv_wdata  = 1'b0;
    rem_start  = 1'b0;
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_base   = '0;
    case (state)
      S_SWEEP: begin
        used_we    = 1'b1;
        used_waddr = sweep_addr;
        rsv_we     = 1'b1;
        rsv_waddr  = sweep_addr;
        fin        = sweep_end && reply;
      end
      S_IDLE: begin
        if (accept) begin
          rem_start = (cmd_in == CMD_ALLOC) && !ignore_in && !nofit_in;
          if (ignore_in) begin
            fin        = 1'b1;
            fin_status = ST_IGNORED;
          end else if (nofit_in) begin
            fin        = 1'b1;
            fin_status = ST_NO_RUN;
          end
        end
      end
      S_RSV_RD:  raddr = req_index;
      S_RSV_CHK: begin
        rsv_we    = !rsv_rdata;
        rsv_wdata = 1'b1;
        fin       = 1'b1;
      end
      S_SCAN: begin
        if (scan_fail) begin
          fin        = 1'b1;
          fin_status = ST_NO_RUN;
        end
      end
      S_MARK: begin
        used_we    = 1'b1;
        used_wdata = 1'b1;
        fin        = mark_last;
        fin_base   = run_begin;
      end
      S_FREE: begin
        used_we = !free_end;
        fin     = free_end;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use      <= CNT_W'(NUM_FRAMES);
      usable_frame_count <= CNT_W'(NUM_FRAMES);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAMES_IN_USE: frames_in_use      <= cfg_data;
        REG_USABLE_COUNT:  usable_frame_count <= cfg_data;
        default:           frames_in_use      <= frames_in_use;
      endcase
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
    if (fin) begin
      status     <= fin_status;
      base_frame <= fin_base;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      reply             <= 1'b0;
      sweep_addr        <= '0;
      search_start      <= '0;
      used_counter      <= '0;
      free_counter      <= CNT_W'(NUM_FRAMES);
      allocated_counter <= '0;
      eval_valid        <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: sweep_addr <= sweep_addr + 1'b1;
        S_IDLE: begin
          if (accept) begin
            req_index <= frame_index;
            req_count <= page_count;
            walk_addr <= {1'b0, frame_index};
            walk_left <= page_count;
            if (cmd_in == CMD_CLEAR) begin
              reply             <= 1'b1;
              sweep_addr        <= '0;
              search_start      <= '0;
              used_counter      <= '0;
              allocated_counter <= '0;
              free_counter      <= sat_limit(usable_frame_count);
            end else if (cmd_in == CMD_FREE && !ignore_in) begin
              used_counter      <= sat_sub(used_counter, page_count);
              free_counter      <= sat_add(free_counter, page_count);
              allocated_counter <= sat_sub(allocated_counter, page_count);
            end
          end
        end
        S_RSV_CHK: begin
          if (!rsv_rdata) begin
            used_counter <= sat_add(used_counter, CNT_W'(1));
            free_counter <= sat_sub(free_counter, CNT_W'(1));
          end
        end
        S_MOD: begin
          scan_addr  <= rem_value;
          issued     <= '0;
          evaluated  <= '0;
          run        <= '0;
          eval_valid <= 1'b0;
        end
        S_SCAN: begin
          // read one frame ahead of the evaluation
          if (issued != total) begin
            eval_frame <= scan_addr;
            eval_valid <= 1'b1;
            scan_addr  <= scan_wrap;
            issued     <= issued + 1'b1;
          end else begin
            eval_valid <= 1'b0;
          end
          if (eval_valid) begin
            evaluated <= evaluated + 1'b1;
            if (frame_free) begin
              run       <= run_inc;
              run_begin <= begin_new;
            end else begin
              run <= '0;
            end
          end
          if (scan_found) begin
            walk_addr <= {1'b0, begin_new};
            walk_left <= req_count;
          end
        end
        S_MARK: begin
          walk_addr <= walk_addr + 1'b1;
          walk_left <= walk_left - 1'b1;
          if (mark_last) begin
            search_start      <= walk_addr + 1'b1;
            used_counter      <= sat_add(used_counter, req_count);
            free_counter      <= sat_sub(free_counter, req_count);
            allocated_counter <= sat_add(allocated_counter, req_count);
          end
        end
        S_FREE: begin
          if (!free_end) begin
            walk_addr <= walk_addr + 1'b1;
            walk_left <= walk_left - 1'b1;
          end
        end
        default: reply <= reply;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_base_zero_unless_done: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_DONE) |-> base_frame == '0)
    else $error("base frame set on a result that is not done");

  a_counters_saturate: assert property (@(posedge clk) disable iff (rst)
    (used_counter <= CNT_W'(NUM_FRAMES)) && (free_counter <= CNT_W'(NUM_FRAMES)) &&
    (allocated_counter <= CNT_W'(NUM_FRAMES)))
    else $error("frame counter above the frame total");

  a_mark_no_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK |-> walk_addr < total)
    else $error("allocated run runs past the last frame");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (evaluated < total) && (evaluated <= issued))
    else $error("scan went past the frame total");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> {1'b0, rem_value} < total)
    else $error("search start not folded below the frame total");
`endif

endmodule
